>>> hw/rtl/mnpt_pkg.sv
// Shared types and constants for the MIDI note pairing timer.
// No dependencies; imported by the interfaces and the top level.
`timescale 1ns / 1ps

package mnpt_pkg;

    localparam int KEY_COUNT  = 128;
    localparam int KEY_W      = $clog2(KEY_COUNT);
    localparam int TICK_W     = 32;
    localparam int TEMPO_W    = 24;
    localparam int TPQ_W      = 15;
    localparam int CHAN_W     = 4;
    localparam int VEL_W      = 7;
    localparam int MASK_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // tick * tempo, then doubled plus a rounding term
    localparam int PROD_W = TICK_W + TEMPO_W;
    localparam int VAL_W  = PROD_W + 2;
    // divisor is at most 2000 * (2^15 - 1)
    localparam int DEN_W  = 26;
    localparam int CNT_W  = $clog2(VAL_W);

    localparam logic [7:0]         STATUS_META  = 8'hFF;
    localparam logic [7:0]         META_TEMPO   = 8'h51;
    localparam logic [3:0]         CMD_NOTE_ON  = 4'h9;
    localparam logic [3:0]         CMD_NOTE_OFF = 4'h8;
    localparam logic [3:0]         CHAN_SKIP    = 4'h9;
    localparam logic [9:0]         SCALE        = 10'd1000;
    localparam logic [TEMPO_W-1:0] TEMPO_RESET  = 24'd1000000;
    localparam logic [TPQ_W-1:0]   TPQ_RESET    = 15'd96;
    localparam logic [MASK_W-1:0]  MASK_RESET   = 16'hFFFF;

    typedef enum logic [1:0] {
        UNIT_TICKS,
        UNIT_BEATS,
        UNIT_SECONDS,
        UNIT_MSEC
    } t_unit;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIME_UNIT,
        CFG_TPQ,
        CFG_CHAN_MASK
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_PREP,
        ST_DIV,
        ST_FIN
    } t_state;

endpackage

>>> hw/rtl/mnpt_evt_if.sv
// Input channel carrying one MIDI event item.
// Depends on mnpt_pkg for field widths.
`timescale 1ns / 1ps

interface mnpt_evt_if
    import mnpt_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [7:0]        status_byte;
    logic [7:0]        data_one;
    logic [7:0]        data_two;
    logic [7:0]        data_three;
    logic [7:0]        data_four;
    logic [7:0]        data_five;
    logic [TICK_W-1:0] abs_tick;

    modport source (
        output valid, status_byte, data_one, data_two, data_three, data_four,
               data_five, abs_tick,
        input  ready
    );

    modport sink (
        input  valid, status_byte, data_one, data_two, data_three, data_four,
               data_five, abs_tick,
        output ready
    );
endinterface

>>> hw/rtl/mnpt_note_if.sv
// Output channel carrying one note record item.
// Depends on mnpt_pkg for field widths; time width is a parameter.
`timescale 1ns / 1ps

interface mnpt_note_if
    import mnpt_pkg::*;
#(
    parameter int TIME_WIDTH = 48
);
    logic                  valid;
    logic                  ready;
    logic [TIME_WIDTH-1:0] start_time;
    logic [TIME_WIDTH-1:0] stop_time;
    logic [KEY_W-1:0]      note_key;
    logic [VEL_W-1:0]      note_velocity;
    logic [CHAN_W-1:0]     note_channel;

    modport source (
        output valid, start_time, stop_time, note_key, note_velocity, note_channel,
        input  ready
    );

    modport sink (
        input  valid, start_time, stop_time, note_key, note_velocity, note_channel,
        output ready
    );
endinterface

>>> hw/rtl/midi_note_pairing_timer.sv
// MIDI note on/off pairing timer: top level.
// Depends on mnpt_pkg, mnpt_evt_if, mnpt_note_if and mnpt_ram.
//
// Use: MIDI events enter on i_evt (valid/ready), one at a time. A tempo meta
// event loads the tempo; a note-on stores its converted time and velocity in
// the key RAM; a matching note-off leaves one note record on o_note. Events
// of channel nine low nibble, other commands and keys above 127 pass with no
// result. The user must write config on i_cfg_we/i_cfg_idx/i_cfg_data only
// while idle; the block itself does not enforce it.
// Timing: an event that touches no key is taken in ST_IDLE alone. A note event
// in the tick unit passes ST_MUL, ST_PREP and ST_FIN; in beats, seconds or
// milliseconds with a nonzero r_tpq it also passes ST_DIV, the restoring
// divider, which retires one quotient bit per cycle over a 58-bit numerator.
// The key RAM read is issued at accept time. A new event is taken as soon as
// the previous one is finished, even while its note record still sits in the
// output register. If that register is still full when the next record is
// ready, the block waits in its last step until o_note.ready frees it.
// Reset: synchronous, active low; clears the started flags of all keys,
// restores tempo and config defaults and empties the output register.
`timescale 1ns / 1ps

module midi_note_pairing_timer
    import mnpt_pkg::*;
#(
    parameter int TIME_WIDTH = 48
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    mnpt_evt_if.sink              i_evt,
    mnpt_note_if.source           o_note
);
    localparam int EXT_W = (TIME_WIDTH > VAL_W) ? TIME_WIDTH : VAL_W;
    localparam int RAM_W = TIME_WIDTH + VEL_W;

    // configuration and tempo
    t_unit              r_time_unit;
    logic [TPQ_W-1:0]   r_tpq;
    logic [MASK_W-1:0]  r_chan_mask;
    logic [TEMPO_W-1:0] r_tempo;
    logic [KEY_COUNT-1:0] r_started;

    t_state r_state, n_state;

    // event being worked on
    logic [TICK_W-1:0] r_tick;
    logic [KEY_W-1:0]  r_key;
    logic [VEL_W-1:0]  r_vel;
    logic [CHAN_W-1:0] r_chan;
    logic              r_is_on;

    // arithmetic
    logic [PROD_W-1:0] r_prod;
    logic [VAL_W-1:0]  r_num;
    logic [DEN_W-1:0]  r_den;
    logic [DEN_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_force_max;

    // output register
    logic                  r_out_valid;
    logic [TIME_WIDTH-1:0] r_out_start;
    logic [TIME_WIDTH-1:0] r_out_stop;
    logic [KEY_W-1:0]      r_out_key;
    logic [VEL_W-1:0]      r_out_vel;
    logic [CHAN_W-1:0]     r_out_chan;

    // control
    logic in_ready, accept, relevant;
    logic do_mul, do_prep, do_div, ram_we, out_load;

    logic [TEMPO_W-1:0] mul_b;
    logic [PROD_W-1:0]  prod;
    logic [DEN_W-1:0]   tpq_scaled;
    logic [VAL_W-1:0]   addend;
    logic [VAL_W-1:0]   num;
    logic [DEN_W-1:0]   den;
    logic [DEN_W:0]     rem_sh;
    logic               rem_ge;
    logic [DEN_W:0]     rem_sub;
    logic [EXT_W-1:0]   val_ext;
    logic [TIME_WIDTH-1:0] fin_time;
    logic               emit_ok;

    logic [RAM_W-1:0] ram_rdata;

    assign accept = i_evt.valid && in_ready;
    assign relevant = (i_evt.status_byte[3:0] != CHAN_SKIP)
                   && (i_evt.status_byte[7:4] == CMD_NOTE_ON
                       || i_evt.status_byte[7:4] == CMD_NOTE_OFF)
                   && !i_evt.data_one[7];

    // multiply: tick by 1000 or by tempo
    assign mul_b = (r_time_unit == UNIT_TICKS || r_time_unit == UNIT_BEATS)
                 ? TEMPO_W'(SCALE) : r_tempo;
    assign prod  = PROD_W'(r_tick) * PROD_W'(mul_b);

    // numerator and divisor for rounding half up
    assign tpq_scaled = DEN_W'(r_tpq) * DEN_W'(SCALE);
    assign addend = (r_time_unit == UNIT_SECONDS) ? VAL_W'(tpq_scaled) : VAL_W'(r_tpq);
    assign num    = VAL_W'({r_prod, 1'b0}) + addend;
    assign den    = (r_time_unit == UNIT_SECONDS) ? {tpq_scaled[DEN_W-2:0], 1'b0}
                                                  : DEN_W'({r_tpq, 1'b0});

    // one restoring division step
    assign rem_sh  = {r_rem, r_num[VAL_W-1]};
    assign rem_ge  = rem_sh >= {1'b0, r_den};
    assign rem_sub = rem_sh - {1'b0, r_den};

    assign val_ext  = EXT_W'(r_num);
    assign fin_time = (r_force_max || val_ext > EXT_W'({TIME_WIDTH{1'b1}}))
                    ? {TIME_WIDTH{1'b1}} : val_ext[TIME_WIDTH-1:0];
    assign emit_ok  = r_started[r_key] && r_chan_mask[r_chan];

    always_comb begin
        n_state  = r_state;
        in_ready = 1'b0;
        do_mul   = 1'b0;
        do_prep  = 1'b0;
        do_div   = 1'b0;
        ram_we   = 1'b0;
        out_load = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (i_evt.valid && relevant) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                do_mul  = 1'b1;
                n_state = ST_PREP;
            end
            ST_PREP: begin
                do_prep = 1'b1;
                if (r_time_unit == UNIT_TICKS || r_tpq == '0) begin
                    n_state = ST_FIN;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                do_div = 1'b1;
                if (r_cnt == '0) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (r_is_on) begin
                    ram_we  = 1'b1;
                    n_state = ST_IDLE;
                end else if (!emit_ok) begin
                    n_state = ST_IDLE;
                end else if (!r_out_valid || o_note.ready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_time_unit <= UNIT_BEATS;
            r_tpq       <= TPQ_RESET;
            r_chan_mask <= MASK_RESET;
            r_tempo     <= TEMPO_RESET;
            r_started   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TIME_UNIT: r_time_unit <= t_unit'(i_cfg_data[1:0]);
                    CFG_TPQ:       r_tpq       <= i_cfg_data[TPQ_W-1:0];
                    CFG_CHAN_MASK: r_chan_mask <= i_cfg_data[MASK_W-1:0];
                    default: ;
                endcase
            end
            if (accept && i_evt.status_byte == STATUS_META
                       && i_evt.data_one == META_TEMPO) begin
                r_tempo <= {i_evt.data_three, i_evt.data_four, i_evt.data_five};
            end
            if (ram_we) begin
                r_started[r_key] <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_note.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_tick  <= i_evt.abs_tick;
            r_key   <= i_evt.data_one[KEY_W-1:0];
            r_vel   <= i_evt.data_two[VEL_W-1:0];
            r_chan  <= i_evt.status_byte[3:0];
            r_is_on <= (i_evt.status_byte[7:4] == CMD_NOTE_ON) && (i_evt.data_two != '0);
        end
        if (do_mul) begin
            r_prod <= prod;
        end
        if (do_prep) begin
            r_rem <= '0;
            r_den <= den;
            r_cnt <= CNT_W'(VAL_W - 1);
            if (r_time_unit == UNIT_TICKS) begin
                r_num       <= VAL_W'(r_prod);
                r_force_max <= 1'b0;
            end else begin
                r_num       <= num;
                r_force_max <= (r_tpq == '0);
            end
        end
        if (do_div) begin
            // numerator shifts out at the top, quotient shifts in at the bottom
            r_num <= {r_num[VAL_W-2:0], rem_ge};
            r_rem <= rem_ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            r_cnt <= r_cnt - 1'b1;
        end
        if (out_load) begin
            // key RAM output still holds the read issued at accept
            r_out_start <= ram_rdata[TIME_WIDTH-1:0];
            r_out_vel   <= ram_rdata[RAM_W-1:TIME_WIDTH];
            r_out_stop  <= fin_time;
            r_out_key   <= r_key;
            r_out_chan  <= r_chan;
        end
    end

    mnpt_ram #(
        .WIDTH (RAM_W),
        .DEPTH (KEY_COUNT)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_key),
        .i_wdata ({r_vel, fin_time}),
        .i_re    (accept),
        .i_raddr (i_evt.data_one[KEY_W-1:0]),
        .o_rdata (ram_rdata)
    );

    assign i_evt.ready          = in_ready;
    assign o_note.valid         = r_out_valid;
    assign o_note.start_time    = r_out_start;
    assign o_note.stop_time     = r_out_stop;
    assign o_note.note_key      = r_out_key;
    assign o_note.note_velocity = r_out_vel;
    assign o_note.note_channel  = r_out_chan;
endmodule

>>> hw/rtl/mnpt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module mnpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds until the next read
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
